>>> sv/tets_pkg.sv
`timescale 1ns / 1ps

package tets_pkg;

	// Table geometry
	localparam int EVENT_SLOTS = 64;
	localparam int LIGHT_COUNT = 32;
	localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int IDX_W       = $clog2(EVENT_SLOTS + 1);

	// Field widths
	localparam int CMD_W    = 2;
	localparam int ID_W     = 8;
	localparam int DAY_W    = 4;
	localparam int MIN_W    = 11;
	localparam int WDAY_W   = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCHED_ON  = 2'd0,
		CMD_SCHED_OFF = 2'd1,
		CMD_REMOVE    = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ACTION = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

	// Day codes
	localparam logic [DAY_W-1:0] DAY_SUN     = 4'd0;
	localparam logic [DAY_W-1:0] DAY_SAT     = 4'd6;
	localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
	localparam logic [DAY_W-1:0] DAY_WEEKDAY = 4'd8;
	localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;

	// Day-of-week values
	localparam logic [WDAY_W-1:0] WD_SUN = 3'd0;
	localparam logic [WDAY_W-1:0] WD_MON = 3'd1;
	localparam logic [WDAY_W-1:0] WD_FRI = 3'd5;
	localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;

	// Stored event, 24 bits: action on top, then minute, day code, light id
	typedef struct packed {
		logic             on;
		logic [MIN_W-1:0] minute;
		logic [DAY_W-1:0] day;
		logic [ID_W-1:0]  id;
	} entry_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;      // latch a new request, restart the scan
		logic scan_en;   // walk the table
		logic fin_push;  // write the closing result
	} ctl_t;

	// Datapath -> controller
	typedef struct packed {
		logic bad_id;    // schedule request with light id out of range
		logic scan_done; // scan has reached its end this cycle
		logic out_free;  // output register can take a result
	} sts_t;

	function automatic logic day_match(input logic [DAY_W-1:0] code,
	                                   input logic [WDAY_W-1:0] today);
		logic m;
		m = 1'b0;
		case (code) inside
			[DAY_SUN:DAY_SAT]: m = (code[WDAY_W-1:0] == today);
			DAY_EVERY:         m = 1'b1;
			DAY_WEEKDAY:       m = (today >= WD_MON) && (today <= WD_FRI);
			DAY_WEEKEND:       m = (today == WD_SUN) || (today == WD_SAT);
			default:           m = 1'b0;
		endcase
		return m;
	endfunction

endpackage

>>> sv/tets_ctrl.sv
`timescale 1ns / 1ps

module tets_ctrl
	import tets_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ctl          = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = sts.bad_id ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.fin_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/tets_dp.sv
`timescale 1ns / 1ps

module tets_dp
	import tets_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [ID_W-1:0]     light_id,
	input  logic [DAY_W-1:0]    day_code,
	input  logic [MIN_W-1:0]    minute,
	input  logic [WDAY_W-1:0]   today,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     out_light,
	output logic                turn_on,
	output logic                last
);

	// latched request
	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [DAY_W-1:0]  day_q;
	logic [MIN_W-1:0]  min_q;
	logic [WDAY_W-1:0] today_q;
	logic              bad_q;
	logic              written_q;

	// table
	entry_t            slot_mem_q [EVENT_SLOTS];
	logic [EVENT_SLOTS-1:0] slot_vld_q;

	// scan: read stage and evaluate stage
	logic [IDX_W-1:0]  idx_q;
	logic              s1_vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;
	entry_t            ent_s1;

	// pending action, held back until we know whether it is the final one
	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              pend_on_q;

	// output register
	logic                out_vld_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     light_q;
	logic                on_q;
	logic                last_q;

	logic is_sched, is_tick, is_remove;
	logic out_free, due, stall, adv, issue, fire;
	logic wr_en, clr_en, push_pend, key_hit, at_end;
	entry_t new_ent;

	assign is_sched  = (cmd_q == CMD_SCHED_ON) || (cmd_q == CMD_SCHED_OFF);
	assign is_tick   = (cmd_q == CMD_TICK);
	assign is_remove = (cmd_q == CMD_REMOVE);

	assign out_free  = !out_vld_q || out_ready;

	assign due     = vld_s1 && day_match(ent_s1.day, today_q) && (ent_s1.minute == min_q);
	assign key_hit = vld_s1 && (ent_s1.id == id_q) && (ent_s1.day == day_q)
	                 && (ent_s1.minute == min_q);

	// a due event with one already pending must move the older one out first
	assign stall = s1_vld_s1 && is_tick && due && pend_vld_q && !out_free;
	assign adv   = ctl.scan_en && !stall;
	assign issue = adv && (idx_q < IDX_W'(EVENT_SLOTS));
	assign fire  = adv && s1_vld_s1;

	assign wr_en     = fire && is_sched && !vld_s1;
	assign clr_en    = fire && is_remove && key_hit;
	assign push_pend = fire && is_tick && due && pend_vld_q;
	assign at_end    = (idx_s1 == SLOT_W'(EVENT_SLOTS - 1));

	assign new_ent.on     = (cmd_q == CMD_SCHED_ON);
	assign new_ent.minute = min_q;
	assign new_ent.day    = day_q;
	assign new_ent.id     = id_q;

	assign sts.bad_id    = ((cmd == CMD_SCHED_ON) || (cmd == CMD_SCHED_OFF))
	                       && (light_id >= ID_W'(LIGHT_COUNT));
	assign sts.scan_done = fire && (at_end || wr_en);
	assign sts.out_free  = out_free;

	// request latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(cmd);
			id_q    <= light_id;
			day_q   <= day_code;
			min_q   <= minute;
			today_q <= today;
			bad_q   <= sts.bad_id;
		end
	end

	// table storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[idx_s1] <= new_ent;
		end
		if (issue) begin
			ent_s1 <= slot_mem_q[idx_q[SLOT_W-1:0]];
			vld_s1 <= slot_vld_q[idx_q[SLOT_W-1:0]];
			idx_s1 <= idx_q[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			idx_q      <= '0;
			s1_vld_s1  <= 1'b0;
			written_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				slot_vld_q[idx_s1] <= 1'b1;
			end else if (clr_en) begin
				slot_vld_q[idx_s1] <= 1'b0;
			end

			if (ctl.load) begin
				idx_q      <= '0;
				s1_vld_s1  <= 1'b0;
				written_q  <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (adv) begin
					s1_vld_s1 <= issue;
				end else if (!ctl.scan_en) begin
					s1_vld_s1 <= 1'b0;
				end
				if (wr_en) begin
					written_q <= 1'b1;
				end
				if (fire && is_tick && due) begin
					pend_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_tick && due) begin
			pend_id_q <= ent_s1.id;
			pend_on_q <= ent_s1.on;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push_pend || ctl.fin_push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			status_q <= ST_ACTION;
			light_q  <= pend_id_q;
			on_q     <= pend_on_q;
			last_q   <= 1'b0;
		end else if (ctl.fin_push) begin
			last_q  <= 1'b1;
			light_q <= '0;
			on_q    <= 1'b0;
			if (bad_q) begin
				status_q <= ST_BAD_ID;
			end else if (is_tick) begin
				if (pend_vld_q) begin
					status_q <= ST_ACTION;
					light_q  <= pend_id_q;
					on_q     <= pend_on_q;
				end else begin
					status_q <= ST_NONE;
				end
			end else if (is_sched) begin
				status_q <= written_q ? ST_OK : ST_FULL;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign out_light = light_q;
	assign turn_on   = on_q;
	assign last      = last_q;

endmodule

>>> sv/timed_event_table_scheduler.sv
// Timed light event table: holds up to EVENT_SLOTS events (light id, day code,
// minute of day, on/off action) and answers requests on a valid/ready channel.
// Request cmd: schedule on / schedule off store the event in the lowest free
// slot, remove frees every slot matching id, day code and minute, tick scans
// for due events at (today, minute).
// Result channel (valid/ready): schedule and remove give one result (ok, id
// out of range, table full). A tick gives one light action per due event in
// slot order, or a single no-action result; the final result carries last.
// Scan: the table sits in a memory, read once per cycle by a scan counter
// unless the scan is stalled. A request passes through the accept, one read,
// a visit to each slot (all 64 for tick and remove, up to the first free slot
// for a schedule) and the closing result. An out-of-range schedule goes from
// the accept straight to the closing result.
// Only one request is in flight; the next is taken once the closing result
// is in the output register, even if the receiver has not yet taken it.
// When the receiver stalls, the scan halts on a due event until the output
// register drains; no result is dropped. Reset empties the table (valid bits
// cleared at once, no clearing pass) and clears the result channel.
`timescale 1ns / 1ps

module timed_event_table_scheduler
	import tets_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [ID_W-1:0]     light_id,
	input  logic [DAY_W-1:0]    day_code,
	input  logic [MIN_W-1:0]    minute,
	input  logic [WDAY_W-1:0]   today,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     out_light,
	output logic                turn_on,
	output logic                last
);

	ctl_t ctl;
	sts_t sts;

	// sequencer: idle / scan / close
	tets_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// table memory, scan pipeline, pending action and output register
	tets_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.light_id  (light_id),
		.day_code  (day_code),
		.minute    (minute),
		.today     (today),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_light (out_light),
		.turn_on   (turn_on),
		.last      (last)
	);

endmodule
